// ----- rtl/sfd_pkg.sv -----
package sfd_pkg;

    localparam logic [7:0] HDR_BYTE   = 8'hAD;
    localparam logic [7:0] CMD_LEAD   = 8'hAA;
    localparam logic [7:0] CMD_TAIL   = 8'h11;
    localparam int         WIN_BYTES  = 5;
    localparam int         PAY_BYTES  = 8;
    localparam logic [3:0] PHASE_IDLE = 4'd0;
    localparam logic [3:0] PHASE_DONE = 4'd9;

    typedef logic [7:0]  byte_t;
    typedef logic [31:0] word_t;

    typedef struct packed {
        logic  valid;
        logic  found;
        word_t freq;
        word_t amp;
        logic  cmd;
    } burst_sum_t;

endpackage

// ----- rtl/sfd_byte_if.sv -----
interface sfd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       burst_end;

    modport source (output valid, output rx_byte, output burst_end, input ready);
    modport sink (input valid, input rx_byte, input burst_end, output ready);
endinterface

// ----- rtl/sfd_result_if.sv -----
interface sfd_result_if;
    logic        valid;
    logic        ready;
    logic        frame_found;
    logic [31:0] freq_value;
    logic [31:0] amp_tenths;
    logic        freq_diff;
    logic        amp_diff;
    logic        start_command;

    modport source (
        output valid, output frame_found, output freq_value, output amp_tenths,
        output freq_diff, output amp_diff, output start_command,
        input ready
    );
    modport sink (
        input valid, input frame_found, input freq_value, input amp_tenths,
        input freq_diff, input amp_diff, input start_command,
        output ready
    );
endinterface

// ----- rtl/sfd_parser.sv -----
module sfd_parser (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               beat,
    input  sfd_pkg::byte_t     rx_byte,
    input  logic               burst_end,
    output sfd_pkg::burst_sum_t sum
);
    import sfd_pkg::*;

    logic [8*WIN_BYTES-1:0] window_reg, window_next;
    logic [3:0]             phase_reg, phase_next;
    logic                   cmd_reg, cmd_next;
    byte_t                  payload_reg [PAY_BYTES];
    byte_t                  payload_next [PAY_BYTES];
    logic                   cmd_hit;
    logic                   hdr_hit;
    logic                   collecting;
    logic [2:0]             lane_idx;
    logic [3:0]             phase_m1;

    assign cmd_hit = window_reg[39:32] == CMD_LEAD && window_reg[31:24] == CMD_LEAD
                  && window_reg[23:16] == CMD_LEAD && window_reg[15:8] == CMD_LEAD
                  && window_reg[7:0] == CMD_TAIL && rx_byte == CMD_TAIL;
    assign hdr_hit = window_reg[23:16] == HDR_BYTE && window_reg[15:8] == HDR_BYTE
                  && window_reg[7:0] == HDR_BYTE && rx_byte == HDR_BYTE;
    assign collecting = phase_reg != PHASE_IDLE && phase_reg < PHASE_DONE;
    assign phase_m1   = phase_reg - 4'd1;
    assign lane_idx   = phase_m1[2:0];
    assign cmd_next   = cmd_reg | cmd_hit;

    always_comb
    begin
        phase_next = phase_reg;
        if (phase_reg == PHASE_IDLE)
        begin
            if (hdr_hit)
            begin
                phase_next = 4'd1;
            end
        end
        else if (collecting)
        begin
            phase_next = phase_reg + 4'd1;
        end
        for (int k = 0; k < PAY_BYTES; k++)
        begin
            payload_next[k] = (collecting && lane_idx == 3'(k)) ? rx_byte : payload_reg[k];
        end
        window_next = {window_reg[8*WIN_BYTES-9:0], rx_byte};
    end

    always_comb
    begin
        sum.valid = beat && burst_end;
        sum.found = phase_next >= PHASE_DONE;
        sum.freq  = {payload_next[3], payload_next[2], payload_next[1], payload_next[0]};
        sum.amp   = {payload_next[7], payload_next[6], payload_next[5], payload_next[4]};
        sum.cmd   = cmd_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= '0;
            phase_reg  <= PHASE_IDLE;
            cmd_reg    <= 1'b0;
        end
        else if (beat)
        begin
            if (burst_end)
            begin
                window_reg <= '0;
                phase_reg  <= PHASE_IDLE;
                cmd_reg    <= 1'b0;
            end
            else
            begin
                window_reg <= window_next;
                phase_reg  <= phase_next;
                cmd_reg    <= cmd_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (beat)
        begin
            payload_reg <= payload_next;
        end
    end

endmodule

// ----- rtl/sfd_tracker.sv -----
module sfd_tracker (
    input  logic                clk,
    input  logic                rst_n,
    input  sfd_pkg::burst_sum_t sum,
    output logic                load_ok,
    sfd_result_if.source        result
);
    import sfd_pkg::*;

    word_t held_freq_reg, held_freq_next;
    word_t held_amp_reg, held_amp_next;
    logic  out_valid_reg;
    logic  found_reg;
    logic  fchg_reg, fchg_next;
    logic  achg_reg, achg_next;
    logic  cmd_reg;

    assign load_ok = !out_valid_reg || result.ready;

    always_comb
    begin
        fchg_next      = sum.found && sum.freq != held_freq_reg;
        achg_next      = sum.found && sum.amp != held_amp_reg;
        held_freq_next = sum.found ? sum.freq : held_freq_reg;
        held_amp_next  = sum.found ? sum.amp : held_amp_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            held_freq_reg <= '0;
            held_amp_reg  <= '0;
        end
        else if (sum.valid)
        begin
            out_valid_reg <= 1'b1;
            held_freq_reg <= held_freq_next;
            held_amp_reg  <= held_amp_next;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sum.valid)
        begin
            found_reg <= sum.found;
            fchg_reg  <= fchg_next;
            achg_reg  <= achg_next;
            cmd_reg   <= sum.cmd;
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.frame_found   = found_reg;
    assign result.freq_value    = held_freq_reg;
    assign result.amp_tenths    = held_amp_reg;
    assign result.freq_diff     = fchg_reg;
    assign result.amp_diff      = achg_reg;
    assign result.start_command = cmd_reg;

endmodule

// ----- rtl/serial_frame_decoder_change_detect.sv -----
// Channel | Dir | Payload                                         | Beat
// rx      | in  | rx_byte[7:0], burst_end                         | one byte
// result  | out | frame_found, freq_value[31:0], amp_tenths[31:0], | one per burst
//         |     | freq_diff, amp_diff, start_command              |
//
// One byte per cycle unless rx stalls; the header and command windows are
// compared in the accept cycle. A result is registered from the burst_end beat.
// rx stalls only while a finished result waits and result.ready is low.
// Reset clears the window, phase, command flag and held frequency and amplitude.
module serial_frame_decoder_change_detect (
    input  logic         clk,
    input  logic         rst_n,
    sfd_byte_if.sink     rx,
    sfd_result_if.source result
);
    import sfd_pkg::*;

    burst_sum_t sum;
    logic       load_ok;
    logic       beat;

    assign rx.ready = load_ok;
    assign beat     = rx.valid && load_ok;

    sfd_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .beat      (beat),
        .rx_byte   (rx.rx_byte),
        .burst_end (rx.burst_end),
        .sum       (sum)
    );

    sfd_tracker u_tracker (
        .clk     (clk),
        .rst_n   (rst_n),
        .sum     (sum),
        .load_ok (load_ok),
        .result  (result)
    );

endmodule

// ----- rtl/sfd_checker.sv -----
module sfd_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic in_burst_end,
    input logic out_valid,
    input logic out_ready,
    input logic frame_found,
    input logic freq_diff,
    input logic amp_diff
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result beat dropped while stalled");

    a_chg_needs_frame: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !frame_found |-> !freq_diff && !amp_diff)
        else $error("change flag without frame");

    a_out_from_burst: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready && in_burst_end))
        else $error("result without burst end");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output");

endmodule

bind serial_frame_decoder_change_detect sfd_checker u_sfd_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (rx.valid),
    .in_ready     (rx.ready),
    .in_burst_end (rx.burst_end),
    .out_valid    (result.valid),
    .out_ready    (result.ready),
    .frame_found  (result.frame_found),
    .freq_diff    (result.freq_diff),
    .amp_diff     (result.amp_diff)
);
